/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; define ASSERT_OFF to drop them all.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// property must hold at every clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

/* hw/rtl/trp_pkg.sv */
// ----------------------------------------------------------------------------
// trp_pkg
// Types and constants shared by the tach trimmed-period speed block.
// ----------------------------------------------------------------------------
package trp_pkg;

    localparam int TIME_W     = 32;
    localparam int RPM_W      = 29;
    localparam int STAT_W     = 2;
    localparam int DIV_W      = 4;
    localparam int ALU_W      = 34;
    localparam int CNT_W      = 5;
    localparam int DIV_STEPS  = 32;
    localparam int MINUTE_US  = 60000000;

    localparam logic [RPM_W-1:0] RPM_MAX = '1;

    // speed status codes
    localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_UNAVAIL = 2'd1;
    localparam logic [STAT_W-1:0] STAT_STOPPED = 2'd2;

    // configuration register indexes (paddr[2])
    localparam logic REG_EXPIRE = 1'b0;
    localparam logic REG_DIVIDE = 1'b1;

    typedef enum logic [3:0] {
        Q_IDLE,
        Q_FIRST,
        Q_EXPCMP,
        Q_DELTA,
        Q_CMP1,
        Q_CMP2,
        Q_SPAN,
        Q_TRIM1,
        Q_TRIM2,
        Q_DIV,
        Q_DONE
    } t_qstate;

    typedef struct packed {
        logic                busy;
        logic                done;
        logic [RPM_W-1:0]    rpm;
        logic [STAT_W-1:0]   status;
    } t_qry_res;

endpackage

/* hw/rtl/trp_ram.sv */
// ----------------------------------------------------------------------------
// trp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module trp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // hold the last read word until the next read
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/trp_alu.sv */
// ----------------------------------------------------------------------------
// trp_alu
// Shared subtractor with sign and zero flags, used for every difference,
// compare and division step of a speed query.
// ----------------------------------------------------------------------------
module trp_alu
    import trp_pkg::*;
(
    input  logic [ALU_W-1:0] i_a,
    input  logic [ALU_W-1:0] i_b,
    output logic [ALU_W-1:0] o_y,
    output logic             o_neg,
    output logic             o_zero
);

    assign o_y    = i_a - i_b;
    assign o_neg  = o_y[ALU_W-1];
    assign o_zero = (o_y == '0);

endmodule

/* hw/rtl/trp_query.sv */
// ----------------------------------------------------------------------------
// trp_query
// Speed query sequencer: walks the stamp ring, keeps the two largest deltas,
// trims them from the span and divides, all through one shared subtractor.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module trp_query
    import trp_pkg::*;
#(
    parameter int STAMPS = 8,
    localparam int IW    = $clog2(STAMPS)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [TIME_W-1:0] i_now,
    input  logic [IW-1:0]     i_first,
    input  logic              i_ring_full,
    input  logic [TIME_W-1:0] i_expire,
    input  logic              i_out_free,
    output logic              o_re,
    output logic [IW-1:0]     o_raddr,
    input  logic [TIME_W-1:0] i_rdata,
    output t_qry_res          o_res
);

    localparam logic [TIME_W-1:0] DIVIDEND = TIME_W'((STAMPS - 3) * MINUTE_US);

    function automatic logic [ALU_W-1:0] sext(input logic [TIME_W-1:0] x);
        return {{(ALU_W-TIME_W){x[TIME_W-1]}}, x};
    endfunction

    function automatic logic [ALU_W-1:0] zext(input logic [TIME_W-1:0] x);
        return {{(ALU_W-TIME_W){1'b0}}, x};
    endfunction

    t_qstate             r_state, n_state;
    logic [TIME_W-1:0]   r_now, n_now;
    logic [TIME_W-1:0]   r_first, n_first;
    logic [TIME_W-1:0]   r_prev, n_prev;
    logic [TIME_W-1:0]   r_delta, n_delta;
    logic [TIME_W-1:0]   r_big1, n_big1;
    logic [TIME_W-1:0]   r_big2, n_big2;
    logic [ALU_W-1:0]    r_acc, n_acc;
    logic [TIME_W-2:0]   r_divisor, n_divisor;
    logic [TIME_W-1:0]   r_quo, n_quo;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic [IW-1:0]       r_rd_ptr, n_rd_ptr;
    logic [RPM_W-1:0]    r_rpm, n_rpm;
    logic [STAT_W-1:0]   r_status, n_status;

    logic [ALU_W-1:0]    alu_a, alu_b, alu_y;
    logic                alu_neg, alu_zero;
    logic [IW-1:0]       ptr_next;
    logic                last_delta;
    logic                div_last;
    logic [ALU_W-1:0]    rem_sh;

    trp_alu u_alu (
        .i_a    (alu_a),
        .i_b    (alu_b),
        .o_y    (alu_y),
        .o_neg  (alu_neg),
        .o_zero (alu_zero)
    );

    assign ptr_next   = (r_rd_ptr == IW'(STAMPS - 1)) ? '0 : r_rd_ptr + IW'(1);
    assign last_delta = (r_cnt == CNT_W'(STAMPS - 1));
    assign div_last   = (r_cnt == CNT_W'(DIV_STEPS - 1));
    assign rem_sh     = {r_acc[ALU_W-2:0], r_quo[TIME_W-1]};

    // operand select for the shared subtractor
    always_comb begin
        alu_a = '0;
        alu_b = '0;
        unique case (r_state)
            Q_FIRST: begin
                alu_a = zext(r_now);
                alu_b = zext(i_rdata);
            end
            Q_EXPCMP: begin
                alu_a = zext(i_expire);
                alu_b = sext(r_delta);
            end
            Q_DELTA: begin
                alu_a = zext(i_rdata);
                alu_b = zext(r_prev);
            end
            Q_CMP1: begin
                alu_a = sext(r_delta);
                alu_b = sext(r_big1);
            end
            Q_CMP2: begin
                alu_a = sext(r_delta);
                alu_b = sext(r_big2);
            end
            Q_SPAN: begin
                alu_a = zext(r_prev);
                alu_b = zext(r_first);
            end
            Q_TRIM1: begin
                alu_a = r_acc;
                alu_b = sext(r_big1);
            end
            Q_TRIM2: begin
                alu_a = r_acc;
                alu_b = sext(r_big2);
            end
            Q_DIV: begin
                alu_a = rem_sh;
                alu_b = {{(ALU_W-TIME_W+1){1'b0}}, r_divisor};
            end
            Q_IDLE, Q_DONE: begin
                alu_a = '0;
                alu_b = '0;
            end
            default: begin
                alu_a = '0;
                alu_b = '0;
            end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            Q_IDLE: begin
                if (i_start) begin
                    n_state = i_ring_full ? Q_FIRST : Q_DONE;
                end
            end
            Q_FIRST:  n_state = Q_EXPCMP;
            Q_EXPCMP: n_state = alu_neg ? Q_DONE : Q_DELTA;
            Q_DELTA:  n_state = Q_CMP1;
            Q_CMP1: begin
                if (alu_neg) begin
                    n_state = Q_CMP2;
                end else begin
                    n_state = last_delta ? Q_SPAN : Q_DELTA;
                end
            end
            Q_CMP2:   n_state = last_delta ? Q_SPAN : Q_DELTA;
            Q_SPAN: begin
                n_state = (alu_y[TIME_W-1] || alu_y[TIME_W-1:0] == '0) ? Q_DONE : Q_TRIM1;
            end
            Q_TRIM1:  n_state = Q_TRIM2;
            Q_TRIM2:  n_state = (alu_neg || alu_zero) ? Q_DONE : Q_DIV;
            Q_DIV:    n_state = div_last ? Q_DONE : Q_DIV;
            Q_DONE:   n_state = i_out_free ? Q_IDLE : Q_DONE;
            default:  n_state = Q_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_now     = r_now;
        n_first   = r_first;
        n_prev    = r_prev;
        n_delta   = r_delta;
        n_big1    = r_big1;
        n_big2    = r_big2;
        n_acc     = r_acc;
        n_divisor = r_divisor;
        n_quo     = r_quo;
        n_cnt     = r_cnt;
        n_rd_ptr  = r_rd_ptr;
        n_rpm     = r_rpm;
        n_status  = r_status;
        o_re      = 1'b0;
        o_raddr   = ptr_next;
        unique case (r_state)
            Q_IDLE: begin
                n_now    = i_now;
                n_big1   = '0;
                n_big2   = '0;
                n_rpm    = '0;
                n_status = STAT_UNAVAIL;
                n_rd_ptr = i_first;
                o_raddr  = i_first;
                o_re     = i_start && i_ring_full;
            end
            Q_FIRST: begin
                n_first = i_rdata;
                n_prev  = i_rdata;
                n_delta = alu_y[TIME_W-1:0];
            end
            Q_EXPCMP: begin
                if (alu_neg) begin
                    n_status = STAT_STOPPED;
                end else begin
                    o_re     = 1'b1;
                    n_rd_ptr = ptr_next;
                    n_cnt    = CNT_W'(1);
                end
            end
            Q_DELTA: begin
                n_delta = alu_y[TIME_W-1:0];
                n_prev  = i_rdata;
            end
            Q_CMP1: begin
                if (!alu_neg) begin
                    n_big2 = r_big1;
                    n_big1 = r_delta;
                    if (!last_delta) begin
                        o_re     = 1'b1;
                        n_rd_ptr = ptr_next;
                        n_cnt    = r_cnt + CNT_W'(1);
                    end
                end
            end
            Q_CMP2: begin
                if (!alu_neg && !alu_zero) begin
                    n_big2 = r_delta;
                end
                if (!last_delta) begin
                    o_re     = 1'b1;
                    n_rd_ptr = ptr_next;
                    n_cnt    = r_cnt + CNT_W'(1);
                end
            end
            Q_SPAN: begin
                n_acc = sext(alu_y[TIME_W-1:0]);
            end
            Q_TRIM1: begin
                n_acc = alu_y;
            end
            Q_TRIM2: begin
                n_divisor = alu_y[TIME_W-2:0];
                n_acc     = '0;
                n_quo     = DIVIDEND;
                n_cnt     = '0;
            end
            Q_DIV: begin
                // restoring step: keep the difference when it does not go negative
                n_acc = alu_neg ? rem_sh : alu_y;
                n_quo = {r_quo[TIME_W-2:0], ~alu_neg};
                n_cnt = r_cnt + CNT_W'(1);
                if (div_last) begin
                    n_status = STAT_OK;
                    n_rpm    = (n_quo[TIME_W-1:RPM_W] != '0) ? RPM_MAX : n_quo[RPM_W-1:0];
                end
            end
            Q_DONE: begin
                o_re = 1'b0;
            end
            default: begin
                o_re = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= Q_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_now     <= n_now;
        r_first   <= n_first;
        r_prev    <= n_prev;
        r_delta   <= n_delta;
        r_big1    <= n_big1;
        r_big2    <= n_big2;
        r_acc     <= n_acc;
        r_divisor <= n_divisor;
        r_quo     <= n_quo;
        r_cnt     <= n_cnt;
        r_rd_ptr  <= n_rd_ptr;
        r_rpm     <= n_rpm;
        r_status  <= n_status;
    end

    assign o_res.busy   = (r_state != Q_IDLE);
    assign o_res.done   = (r_state == Q_DONE) && i_out_free;
    assign o_res.rpm    = r_rpm;
    assign o_res.status = r_status;

    `ASSERT_CLK(a_rpm_zero_unless_ok, i_clk, i_rst_n, (o_res.done && r_status != STAT_OK) |-> (r_rpm == '0), "rpm nonzero on a failed query")
    `ASSERT_NEVER(a_start_when_busy, i_clk, i_rst_n, i_start && r_state != Q_IDLE, "query started while sequencer busy")
    `ASSERT_CLK(a_divisor_nonzero, i_clk, i_rst_n, (r_state == Q_DIV) |-> (r_divisor != '0), "division by a zero trimmed sum")
    `ASSERT_CLK(a_big_order, i_clk, i_rst_n, (r_state == Q_SPAN) |-> (!r_big1[TIME_W-1] && !r_big2[TIME_W-1]), "largest deltas went negative")

endmodule

/* hw/rtl/tach_rpm_trimmed_period.sv */
// ----------------------------------------------------------------------------
// tach_rpm_trimmed_period
// Fan tach speed measurement: records every edge_divide-th clean falling edge
// in a stamp ring and answers speed queries from the trimmed mean period.
// ----------------------------------------------------------------------------
// Channel    Direction  Transaction
// s_axis     in         tach edge (tuser=0) or speed query (tuser=1), with time
// m_axis     out        one speed result per query, none per edge
// apb        in/out     expire_us at 0x0, edge_divide at 0x4
//
// A query, once accepted, walks the ring (STAMPS-1 deltas) through the shared
// subtractor and then runs a 32-step restoring division; an unavailable or
// stopped answer leaves earlier. s_axis_tready is low while a query runs.
// A finished result waits in the output register; edges are still taken.
// Reset is synchronous, active low; the stamp ring needs no clearing.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tach_rpm_trimmed_period
    import trp_pkg::*;
#(
    parameter int STAMPS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // [0] pin_level, [32:1] time_us, rest zero
    input  logic [0:0]  s_axis_tuser,   // [0] req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [28:0] rpm, rest zero
    output logic [1:0]  m_axis_tuser,   // [1:0] speed_status
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IW = $clog2(STAMPS);

    logic [TIME_W-1:0] r_expire;
    logic [DIV_W-1:0]  r_edge_div;
    logic [2:0]        r_edge_phase;
    logic [IW-1:0]     r_newest;
    logic              r_ring_full;
    logic              r_m_valid;
    logic [RPM_W-1:0]  r_m_rpm;
    logic [STAT_W-1:0] r_m_status;

    logic              cfg_wr;
    logic              s_accept;
    logic              is_edge;
    logic              q_start;
    logic [TIME_W-1:0] in_time;
    logic [IW-1:0]     next_idx;
    logic [DIV_W-1:0]  div_eff;
    logic [DIV_W-1:0]  phase_inc;
    logic              record;
    logic              out_free;
    logic              ram_re;
    logic [IW-1:0]     ram_raddr;
    logic [TIME_W-1:0] ram_rdata;
    t_qry_res          q_res;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign prdata   = (paddr[2] == REG_DIVIDE) ? {{(32-DIV_W){1'b0}}, r_edge_div} : r_expire;

    assign s_axis_tready = !q_res.busy;
    assign s_accept = s_axis_tvalid && s_axis_tready;
    assign in_time  = s_axis_tdata[TIME_W:1];
    assign is_edge  = s_accept && !s_axis_tuser[0] && !s_axis_tdata[0];
    assign q_start  = s_accept && s_axis_tuser[0];

    assign next_idx = (r_newest == IW'(STAMPS - 1)) ? '0 : r_newest + IW'(1);

    // clamp divide into 1..8
    always_comb begin
        priority if (r_edge_div == '0) begin
            div_eff = DIV_W'(1);
        end else if (r_edge_div > DIV_W'(8)) begin
            div_eff = DIV_W'(8);
        end else begin
            div_eff = r_edge_div;
        end
    end

    assign phase_inc = {1'b0, r_edge_phase} + DIV_W'(1);
    assign record    = (phase_inc >= div_eff);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expire   <= TIME_W'(2000000);
            r_edge_div <= DIV_W'(2);
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_EXPIRE: r_expire   <= pwdata;
                REG_DIVIDE: r_edge_div <= pwdata[DIV_W-1:0];
                default:    r_expire   <= r_expire;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edge_phase <= 3'd7;
            r_newest     <= IW'(STAMPS - 1);
            r_ring_full  <= 1'b0;
        end else if (is_edge) begin
            if (record) begin
                r_edge_phase <= '0;
                r_newest     <= next_idx;
                if (next_idx == IW'(STAMPS - 1)) begin
                    r_ring_full <= 1'b1;
                end
            end else begin
                r_edge_phase <= phase_inc[2:0];
            end
        end
    end

    trp_ram #(
        .WIDTH (TIME_W),
        .DEPTH (STAMPS)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (is_edge && record),
        .i_waddr (next_idx),
        .i_wdata (in_time),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign out_free = !r_m_valid || m_axis_tready;

    trp_query #(
        .STAMPS (STAMPS)
    ) u_query (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (q_start),
        .i_now       (in_time),
        .i_first     (next_idx),
        .i_ring_full (r_ring_full),
        .i_expire    (r_expire),
        .i_out_free  (out_free),
        .o_re        (ram_re),
        .o_raddr     (ram_raddr),
        .i_rdata     (ram_rdata),
        .o_res       (q_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (q_res.done) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (q_res.done) begin
            r_m_rpm    <= q_res.rpm;
            r_m_status <= q_res.status;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {{(32-RPM_W){1'b0}}, r_m_rpm};
    assign m_axis_tuser  = r_m_status;

    `ASSERT_CLK(a_query_blocks_input, i_clk, i_rst_n, q_start |=> !s_axis_tready, "input taken during a query")
    `ASSERT_NEVER(a_ring_full_sticks, i_clk, i_rst_n, $fell(r_ring_full), "ring full flag dropped")
    `ASSERT_NEVER(a_no_result_overrun, i_clk, i_rst_n, q_res.done && r_m_valid && !m_axis_tready, "result overwrote a pending one")

endmodule
